@@ sv/murmur2_word_stream_hash_defines.svh @@
// Assertion macros for the murmur2_word_stream_hash block.
// Each macro uses the checker's clk and rst and needs no other file.
`ifndef MURMUR2_WORD_STREAM_HASH_DEFINES_SVH
`define MURMUR2_WORD_STREAM_HASH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MWSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MWSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/mwsh_pkg.sv @@
// Shared types, constants and helpers for the MurmurHash2 word stream hash.
// Used by the controller and the datapath; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mwsh_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_TAIL,
    CLS_FULL
  } word_class_t;

  typedef enum logic [2:0] {
    SRC_WORD,
    SRC_KMIX,
    SRC_HASH,
    SRC_HTAIL,
    SRC_HFIN
  } mul_src_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_K,
    DST_H,
    DST_H_XK
  } mul_dst_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_H,
    ST_TAIL,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     take;
    mul_src_t src;
    mul_dst_t dst;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    word_class_t in_cls;
    logic        in_last;
    logic        last;
    logic        out_full;
  } status_t;

  function automatic word_class_t classify(input logic [2:0] count);
    word_class_t cls;
    if (count == 3'd0) begin
      cls = CLS_NONE;
    end else if (count >= 3'd4) begin
      cls = CLS_FULL;
    end else begin
      cls = CLS_TAIL;
    end
    return cls;
  endfunction

  // Keeps the valid bytes of a partial word (one to three bytes).
  function automatic logic [31:0] tail_mask(input logic [2:0] count);
    logic [31:0] mask;
    unique case (count)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

@@ sv/mwsh_ctrl.sv @@
// Sequencer for the MurmurHash2 word stream hash.
// Depends on mwsh_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module mwsh_ctrl
  import mwsh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire logic    m_axis_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (status.in_cls)
            CLS_FULL: state_next = ST_K1;
            CLS_TAIL: state_next = ST_TAIL;
            default:  state_next = status.in_last ? ST_FIN : ST_IDLE;
          endcase
        end
      end
      ST_K1:   state_next = ST_K2;
      ST_K2:   state_next = ST_H;
      ST_H:    state_next = status.last ? ST_FIN : ST_IDLE;
      ST_TAIL: state_next = status.last ? ST_FIN : ST_IDLE;
      ST_FIN:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!status.out_full || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd.take      = 1'b0;
    cmd.src       = SRC_WORD;
    cmd.dst       = DST_NONE;
    cmd.emit      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.take      = s_axis_tvalid;
      end
      ST_K1: begin
        cmd.src = SRC_WORD;
        cmd.dst = DST_K;
      end
      ST_K2: begin
        cmd.src = SRC_KMIX;
        cmd.dst = DST_K;
      end
      ST_H: begin
        cmd.src = SRC_HASH;
        cmd.dst = DST_H_XK;
      end
      ST_TAIL: begin
        cmd.src = SRC_HTAIL;
        cmd.dst = DST_H;
      end
      ST_FIN: begin
        cmd.src = SRC_HFIN;
        cmd.dst = DST_K;
      end
      ST_EMIT: begin
        cmd.emit = !status.out_full || m_axis_tready;
      end
      default: begin
        cmd.take = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/mwsh_datapath.sv @@
// Datapath of the MurmurHash2 word stream hash: seed, running hash,
// one shared 32x32 multiplier and the output register. Depends on mwsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwsh_datapath
  import mwsh_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [31:0]            cfg_data,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tlast,
  input  wire logic                   s_axis_tuser,
  input  wire logic                   m_axis_tready,
  output logic                        m_axis_tvalid,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire cmd_t                   cmd,
  output status_t                     status
);

  logic [31:0] in_word;
  logic [2:0]  in_count;
  logic [31:0] in_length;
  word_class_t in_cls;

  logic [31:0] seed;
  logic [31:0] running_hash;
  logic [31:0] word;
  logic [31:0] k;
  logic        last;

  logic [31:0] mul_a;
  logic [31:0] product;

  assign in_word   = s_axis_tdata[31:0];
  assign in_count  = s_axis_tdata[34:32];
  assign in_length = s_axis_tdata[66:35];
  assign in_cls    = classify(in_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid) begin
      seed <= cfg_data;
    end
  end

  // The operand is pre-masked on entry, so the tail step is a plain XOR.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      word <= in_word & tail_mask(in_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
    end else if (cmd.take) begin
      last <= s_axis_tlast;
    end
  end

  always_comb begin
    unique case (cmd.src)
      SRC_WORD:  mul_a = word;
      SRC_KMIX:  mul_a = k ^ (k >> MIX_SHIFT);
      SRC_HASH:  mul_a = running_hash;
      SRC_HTAIL: mul_a = running_hash ^ word;
      SRC_HFIN:  mul_a = running_hash ^ (running_hash >> FIN_SHIFT_A);
      default:   mul_a = word;
    endcase
  end

  // Only the low 32 bits of the product are ever needed.
  assign product = mul_a * MIX_MUL;

  always_ff @(posedge clk) begin
    if (cmd.dst == DST_K) begin
      k <= product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (cmd.take && s_axis_tuser) begin
      running_hash <= seed ^ in_length;
    end else if (cmd.dst == DST_H) begin
      running_hash <= product;
    end else if (cmd.dst == DST_H_XK) begin
      running_hash <= product ^ k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= k ^ (k >> FIN_SHIFT_B);
    end
  end

  assign status.in_cls   = in_cls;
  assign status.in_last  = s_axis_tlast;
  assign status.last     = last;
  assign status.out_full = m_axis_tvalid;

endmodule

`default_nettype wire

@@ sv/murmur2_word_stream_hash.sv @@
// Top level of the MurmurHash2 word stream hash: controller plus datapath.
// Depends on mwsh_pkg, mwsh_ctrl and mwsh_datapath.
//
//   Channel   Direction  Handshake                       Payload
//   cfg       in         cfg_valid / cfg_ready           cfg_data = seed
//   s_axis    in         s_axis_tvalid / s_axis_tready   tdata, tlast, tuser
//   m_axis    out        m_axis_tvalid / m_axis_tready   tdata = hash_value
//
// A word is taken while idle, then a full word runs through states K1, K2 and
// H on the shared 32x32 multiplier, a partial word through TAIL, and an empty
// word through none. A last word adds the finalization multiply (FIN) and
// the output register load (EMIT).
// The multiplier is the single shared unit, so these steps run in turn.
// Reset (rst, synchronous, active high) clears the seed and the running hash
// to zero and empties the output register. The seed port is always ready.
// A stalled output holds its hash; the next word is still accepted meanwhile,
// and the block waits only when a new hash is ready while the old one waits.
`timescale 1ns / 1ps
`default_nettype none

module murmur2_word_stream_hash
  import mwsh_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Seed register write.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [31:0]            cfg_data,
  // Input words. tdata from bit 0: data_word[31:0], byte_count[34:32],
  // message_length[66:35], zero padding[71:67].
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tlast: last_word.
  input  wire logic                   s_axis_tlast,
  // tuser: first_word.
  input  wire logic                   s_axis_tuser,
  // Results. tdata from bit 0: hash_value[31:0].
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  // The seed can be written in any cycle; writes are expected while idle.
  assign cfg_ready = 1'b1;

  mwsh_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  mwsh_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

`default_nettype wire

@@ sv/mwsh_checker.sv @@
// Port-level checks for murmur2_word_stream_hash, bound to the top level.
// Depends on murmur2_word_stream_hash_defines.svh and mwsh_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur2_word_stream_hash_defines.svh"

module mwsh_checker
  import mwsh_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   s_axis_tlast,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A waiting hash stays put until it is taken.
  `MWSH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output hash changed while stalled")

  // A word that carries bytes or ends a message keeps the block busy for the next cycle.
  // An empty word that does not end a message is finished in the cycle it is taken.
  `MWSH_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready && (s_axis_tlast || (s_axis_tdata[34:32] != 3'd0)), !s_axis_tready, "word accepted back to back")

  // No hash is produced right after a word is taken.
  `MWSH_ASSERT_NEXT(a_no_early_hash, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "hash appeared one cycle after a word")

  // An idle block with no offered word stays ready.
  `MWSH_ASSERT_NEXT(a_idle_stays, s_axis_tready && !s_axis_tvalid, s_axis_tready, "ready dropped without a word")

  // The seed port never stalls.
  `MWSH_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "seed write stalled")

endmodule

bind murmur2_word_stream_hash mwsh_checker u_mwsh_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for murmur2_word_stream_hash: directed words, then random messages.
// Needs only mwsh_pkg and the block's RTL; a built-in hash predictor checks every result.
`timescale 1ns / 1ps

module tb;

  localparam logic [31:0] HASH_MUL     = 32'h5bd1_e995;
  localparam int          CYCLE_LIMIT  = 400000;
  // Covers the slowest word plus finalization and output load, with margin.
  localparam int          SETTLE_WAIT  = 12;
  localparam int          PHASE_WORDS  = 120;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          N_DIRECTED   = 21;
  localparam int          N_PHASES     = 5;

  // One stimulus word plus an optional hash that is known without the predictor.
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        first;
    logic        last;
    logic [31:0] length;
    logic        lit_valid;
    logic [31:0] lit_hash;
  } word_item_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [31:0]                     cfg_data;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // tdata from bit 0: data_word[31:0], byte_count[34:32], message_length[66:35], zeros.
  logic [mwsh_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  // tlast: last_word.
  logic                            s_axis_tlast;
  // tuser: first_word.
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // tdata from bit 0: hash_value[31:0].
  logic [mwsh_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor state: the seed register and the unfinalized running hash.
  logic [31:0] model_seed;
  logic [31:0] model_hash;
  logic [31:0] expected_hash [$];

  int          error_count;
  int          words_sent;
  int          hashes_seen;
  int          cycle_count;
  bit          tx_burst;
  bit          rx_burst;
  bit          hold_request;
  word_item_t  directed_words [0:N_DIRECTED-1];
  logic [31:0] phase_seed [0:N_PHASES-1];

  murmur2_word_stream_hash i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mixes one word into the running hash. Counts of four and above act as a full word,
  // zero leaves the hash alone, one to three bytes take the tail step.
  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w,
                                           input logic [2:0] n);
    logic [31:0] k;
    logic [31:0] r;
    r = h;
    if (n >= 3'd4) begin
      k = w * HASH_MUL;
      k = k ^ (k >> 24);
      k = k * HASH_MUL;
      r = (h * HASH_MUL) ^ k;
    end else if (n != 3'd0) begin
      if (n >= 3'd3) r = r ^ (w & 32'h00ff_0000);
      if (n >= 3'd2) r = r ^ (w & 32'h0000_ff00);
      r = r ^ (w & 32'h0000_00ff);
      r = r * HASH_MUL;
    end
    return r;
  endfunction

  function automatic logic [31:0] finalize_hash(input logic [31:0] h);
    logic [31:0] f;
    f = h ^ (h >> 13);
    f = f * HASH_MUL;
    f = f ^ (f >> 15);
    return f;
  endfunction

  function automatic word_item_t make_word(input logic [31:0] data, input logic [2:0] count,
                                           input logic first, input logic last,
                                           input logic [31:0] length);
    word_item_t w;
    w.data      = data;
    w.count     = count;
    w.first     = first;
    w.last      = last;
    w.length    = length;
    w.lit_valid = 1'b0;
    w.lit_hash  = 32'h0;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %08h expected %08h", $time, what, got, want);
    error_count++;
  endtask

  // Offers one word from a falling edge and returns at the falling edge after
  // it was taken. On acceptance the predictor advances and, for a last word,
  // the finalized hash joins the queue of expected hashes.
  task automatic push_word(input word_item_t w);
    int          gap;
    logic [31:0] start;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = {5'b0, w.length, w.count, w.data};
    s_axis_tlast  = w.last;
    s_axis_tuser  = w.first;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    start      = w.first ? (model_seed ^ w.length) : model_hash;
    model_hash = mix_word(start, w.data, w.count);
    if (w.last) begin
      expected_hash.push_back(w.lit_valid ? w.lit_hash : finalize_hash(model_hash));
    end
    words_sent++;
    @(negedge clk);
  endtask

  // A well-formed message: full words, then a partial word if the length asks
  // for one; an empty message is one empty word. Now and then the length field
  // disagrees, or a full word carries a byte count above four.
  task automatic send_message();
    int          len;
    int          nwords;
    int          pick;
    logic [31:0] len_field;
    logic [2:0]  cnt;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      len = 0;
    end else if (pick < 80) begin
      len = $urandom_range(1, 24);
    end else begin
      len = $urandom_range(25, 64);
    end
    len_field = ($urandom_range(0, 7) == 0) ? $urandom : len;
    if (len == 0) begin
      push_word(make_word($urandom, 3'd0, 1'b1, 1'b1, len_field));
    end else begin
      nwords = (len + 3) / 4;
      for (int i = 0; i < nwords; i++) begin
        if (i == nwords - 1 && len % 4 != 0) begin
          cnt = 3'(len % 4);
        end else if ($urandom_range(0, 9) == 0) begin
          cnt = 3'($urandom_range(5, 7));
        end else begin
          cnt = 3'd4;
        end
        push_word(make_word($urandom, cnt, i == 0, i == nwords - 1, len_field));
      end
    end
  endtask

  // Lets every expected hash arrive, then gives the block time to finish any
  // word that produces no hash, so the seed may be rewritten safely.
  task automatic drain_block();
    s_axis_tvalid = 1'b0;
    while (expected_hash.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_seed = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hash checker: every accepted hash is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_hash.size() == 0) begin
        report_mismatch("unexpected hash", m_axis_tdata, 32'h0);
      end else begin
        if (m_axis_tdata !== expected_hash[0]) begin
          report_mismatch("hash_value", m_axis_tdata, expected_hash[0]);
        end
        void'(expected_hash.pop_front());
      end
      hashes_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("murmur2_word_stream_hash: mismatch");
      $finish;
    end
  end

  // Receiver: a random stall before each hash outside burst phases, and once a long hold-off while
  // the sender keeps offering words, so the block backs up into its input.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = rx_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = 32'h0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    model_seed    = 32'h0;
    model_hash    = 32'h0;
    error_count   = 0;
    words_sent    = 0;
    hashes_seen   = 0;
    cycle_count   = 0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    hold_request  = 1'b0;

    // Directed words, all under seed zero. Fields: data, count, first, last,
    // length, then a literal hash where one is obvious.
    directed_words = '{
      // Empty message with zero length and zero seed hashes to zero.
      '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'd0, 1'b1, 32'h0},
      // Zero valid bytes: the data word must be ignored.
      '{32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'd0, 1'b1, 32'h0},
      // No first word: mixes into the running hash, which is zero here.
      '{32'h0000_0000, 3'd4, 1'b0, 1'b1, 32'd0, 1'b0, 32'h0},
      '{32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'd4, 1'b0, 32'h0},
      // Tail words of one, two and three bytes; upper bytes must be dropped.
      '{32'hffff_ffa5, 3'd1, 1'b1, 1'b1, 32'd1, 1'b0, 32'h0},
      '{32'h1234_5678, 3'd2, 1'b1, 1'b1, 32'd2, 1'b0, 32'h0},
      '{32'hdead_beef, 3'd3, 1'b1, 1'b1, 32'd3, 1'b0, 32'h0},
      // Byte counts five to seven saturate to a full word.
      '{32'h0123_4567, 3'd5, 1'b1, 1'b1, 32'd4, 1'b0, 32'h0},
      '{32'h89ab_cdef, 3'd6, 1'b1, 1'b1, 32'd4, 1'b0, 32'h0},
      '{32'hffff_ffff, 3'd7, 1'b1, 1'b1, 32'd4, 1'b0, 32'h0},
      // A partial word that is not last, followed by a normal full word.
      '{32'h00ab_cdef, 3'd3, 1'b1, 1'b0, 32'd7, 1'b0, 32'h0},
      '{32'h8000_0001, 3'd4, 1'b0, 1'b1, 32'd7, 1'b0, 32'h0},
      // Length field that disagrees with the words, at its maximum.
      '{32'h7fff_ffff, 3'd4, 1'b1, 1'b1, 32'hffff_ffff, 1'b0, 32'h0},
      // Multi-word message with an empty word in the middle and a one-byte tail.
      '{32'h6b65_7931, 3'd4, 1'b1, 1'b0, 32'd13, 1'b0, 32'h0},
      '{32'h6b65_7932, 3'd4, 1'b0, 1'b0, 32'd13, 1'b0, 32'h0},
      '{32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'd13, 1'b0, 32'h0},
      '{32'h6b65_7933, 3'd4, 1'b0, 1'b0, 32'd13, 1'b0, 32'h0},
      '{32'hcafe_f021, 3'd1, 1'b0, 1'b1, 32'd13, 1'b0, 32'h0},
      // After a hash the running value is kept, so mixing simply continues.
      '{32'h5555_aaaa, 3'd4, 1'b0, 1'b1, 32'd0, 1'b0, 32'h0},
      '{32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'd0, 1'b0, 32'h0},
      '{32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'h8000_0000, 1'b0, 32'h0}
    };
    phase_seed = '{32'hffff_ffff, $urandom, 32'h0000_0001, $urandom, 32'h0000_0000};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_seed(32'h0);
    for (int i = 0; i < N_DIRECTED; i++) begin
      push_word(directed_words[i]);
    end
    drain_block();

    // Random phases, each under its own seed. The first runs without any idling,
    // the second keeps the input busy while the receiver holds off for a while.
    for (int p = 0; p < N_PHASES; p++) begin
      tx_burst = (p <= 1);
      rx_burst = (p == 0);
      write_seed(phase_seed[p]);
      if (p == 1) hold_request = 1'b1;
      while (words_sent < N_DIRECTED + (p + 1) * PHASE_WORDS) begin
        if ($urandom_range(0, 9) < 8) begin
          send_message();
        end else begin
          // Noise: any field value, including stray first and last marks.
          push_word(make_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom),
                              1'($urandom), $urandom));
        end
      end
      drain_block();
    end

    if (error_count == 0) begin
      $display("murmur2_word_stream_hash: match");
    end else begin
      $display("murmur2_word_stream_hash: mismatch");
    end
    $finish;
  end

endmodule
